FILE: hdl/evf_pkg.sv
// Shared types and constants for the encoder velocity filter.
// Used by every module under hdl/; depends on nothing.
package evf_pkg;

  localparam int CH_W       = 2;
  localparam int DT_W       = 16;
  localparam int POS_W      = 32;
  localparam int RAW_W      = 26;
  localparam int FILT_W     = 34;
  localparam int COEF_W     = 15;
  localparam int MASK_W     = 4;
  localparam int MAX_OUT    = 4;
  localparam int NUM_W      = 42;
  localparam int MAG_W      = 41;
  localparam int DIVCNT_W   = 6;
  localparam int PROD1_W    = 50;
  localparam int SUM_W      = 27;
  localparam int PROD2_W    = 43;
  localparam int ACC_W      = 53;
  localparam int FRAC_W     = 15;
  localparam int SH_W       = ACC_W - FRAC_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 96;

  localparam logic [9:0]              MS_PER_S    = 10'd1000;
  localparam logic signed [ACC_W-1:0] ACC_ROUND   = ACC_W'(16384);
  localparam logic [COEF_W-1:0]       POLE_RESET  = 15'd27984;
  localparam logic [COEF_W-1:0]       INPUT_RESET = 15'd2386;
  localparam logic [MASK_W-1:0]       MASK_RESET  = 4'd2;

  typedef enum logic [1:0] {
    REG_POLE   = 2'd0,
    REG_INPUT  = 2'd1,
    REG_INVERT = 2'd2
  } evf_reg_t;

  typedef struct packed {
    logic [COEF_W-1:0] pole;
    logic [COEF_W-1:0] in_coef;
    logic [MASK_W-1:0] invert;
  } evf_cfg_t;

  // one classified item waiting for the back end
  typedef struct packed {
    logic            is_tick;
    logic [CH_W-1:0] channel;
    logic            count_up;
    logic [DT_W-1:0] elapsed;
  } evf_cmd_t;

endpackage

FILE: hdl/encoder_velocity_filter_top.sv
// Top level of the encoder velocity filter: stream ports, APB register
// block, front end, item queue and back end. Depends on evf_pkg.
//
// Counts quadrature edges on up to four encoder channels and, on every
// sample tick, emits one velocity result per channel (channel 0 first,
// tlast on the final one). An edge item is taken from the queue and counted
// in the idle state. For a tick, each channel in turn runs through the single
// shared restoring divider, one quotient bit per cycle over 41 bits, then a
// saturate step and the filter multiply, add and saturate steps. A four-entry
// queue lets edge and tick items keep arriving while a tick is being worked off,
// and the result register lets the next channel finish while a result waits.
module encoder_velocity_filter_top #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] b_level, [16:1] elapsed_ms, [23:17] zero
  input  logic [evf_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] command, [2:1] channel
  input  logic [evf_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [25:0] raw_velocity, [59:26] filtered_velocity, [91:60] position,
  // [95:92] zero
  output logic [evf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] out_channel
  output logic [evf_pkg::CH_W-1:0]        out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [evf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [evf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [evf_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import evf_pkg::*;

  localparam int N_OUT = (NUM_CHANNELS < MAX_OUT) ? NUM_CHANNELS : MAX_OUT;

  logic [COEF_W-1:0] pole_r, pole_nxt;
  logic [COEF_W-1:0] incoef_r, incoef_nxt;
  logic [MASK_W-1:0] invert_r, invert_nxt;
  logic              cfg_wr;
  evf_reg_t          cfg_idx;
  evf_cfg_t          cfg;

  logic                     fr_valid, fr_ready;
  evf_cmd_t                 fr_item;
  logic                     q_valid, q_pop;
  evf_cmd_t                 q_item;
  logic signed [RAW_W-1:0]  raw_v;
  logic signed [FILT_W-1:0] filt_v;
  logic signed [POS_W-1:0]  pos_v;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = evf_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    pole_nxt   = pole_r;
    incoef_nxt = incoef_r;
    invert_nxt = invert_r;
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_POLE: begin
        cfg_prdata = CFG_DATA_W'(pole_r);
        if (cfg_wr) pole_nxt = cfg_pwdata[COEF_W-1:0];
      end
      REG_INPUT: begin
        cfg_prdata = CFG_DATA_W'(incoef_r);
        if (cfg_wr) incoef_nxt = cfg_pwdata[COEF_W-1:0];
      end
      REG_INVERT: begin
        cfg_prdata = CFG_DATA_W'(invert_r);
        if (cfg_wr) invert_nxt = cfg_pwdata[MASK_W-1:0];
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r   <= POLE_RESET;
      incoef_r <= INPUT_RESET;
      invert_r <= MASK_RESET;
    end else begin
      pole_r   <= pole_nxt;
      incoef_r <= incoef_nxt;
      invert_r <= invert_nxt;
    end
  end

  assign cfg.pole    = pole_r;
  assign cfg.in_coef = incoef_r;
  assign cfg.invert  = invert_r;

  evf_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_command   (in_tuser[0]),
    .in_channel   (in_tuser[2:1]),
    .in_b_level   (in_tdata[0]),
    .in_elapsed_ms(in_tdata[DT_W:1]),
    .cfg          (cfg),
    .ent_valid    (fr_valid),
    .ent          (fr_item),
    .ent_ready    (fr_ready)
  );

  evf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_item (fr_item),
    .pop_valid (q_valid),
    .pop_ready (q_pop),
    .pop_item  (q_item)
  );

  evf_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_pop                (q_pop),
    .q_item               (q_item),
    .cfg                  (cfg),
    .out_valid            (out_tvalid),
    .out_ready            (out_tready),
    .out_channel          (out_tuser),
    .out_raw_velocity     (raw_v),
    .out_filtered_velocity(filt_v),
    .out_position         (pos_v),
    .out_last             (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - RAW_W - FILT_W - POS_W){1'b0}}, pos_v, filt_v, raw_v};

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == CH_W'(N_OUT - 1))
    else $error("tlast on a result that is not the final channel");

  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast
      |=> !out_tvalid || (out_tuser == $past(out_tuser) + 1'b1))
    else $error("results of a tick out of channel order");

  a_first_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || (out_tuser == '0))
    else $error("tick does not start at channel zero");

endmodule

FILE: hdl/evf_front.sv
// Front end: takes input items, drops edges for absent channels,
// resolves count direction and zero elapsed time. Depends on evf_pkg.
module evf_front #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [evf_pkg::CH_W-1:0] in_channel,
  input  logic                     in_b_level,
  input  logic [evf_pkg::DT_W-1:0] in_elapsed_ms,
  input  evf_pkg::evf_cfg_t        cfg,
  output logic                     ent_valid,
  output evf_pkg::evf_cmd_t        ent,
  input  logic                     ent_ready
);
  import evf_pkg::*;

  logic     hold_valid_r, hold_valid_nxt;
  evf_cmd_t hold_r, hold_nxt;
  logic     accept;
  logic     keep;

  assign in_ready  = !hold_valid_r || ent_ready;
  assign accept    = in_valid && in_ready;
  assign keep      = in_command || (int'(in_channel) < NUM_CHANNELS);
  assign ent_valid = hold_valid_r;
  assign ent       = hold_r;

  always_comb begin
    hold_nxt.is_tick  = in_command;
    hold_nxt.channel  = in_command ? '0 : in_channel;
    hold_nxt.count_up = in_b_level ^ cfg.invert[in_channel];
    hold_nxt.elapsed  = (in_elapsed_ms == '0) ? DT_W'(1) : in_elapsed_ms;
    if (accept) begin
      hold_valid_nxt = keep;
    end else if (ent_ready) begin
      hold_valid_nxt = 1'b0;
    end else begin
      hold_valid_nxt = hold_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

FILE: hdl/evf_queue.sv
// Short item queue between the front and back ends.
// Depends on evf_pkg.
module evf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  evf_pkg::evf_cmd_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output evf_pkg::evf_cmd_t pop_item
);
  import evf_pkg::*;

  evf_cmd_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/evf_back.sv
// Back end: position counters, per-channel velocity by a shared restoring
// divider, low-pass filter and result register. Depends on evf_pkg.
module evf_back #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  evf_pkg::evf_cmd_t                 q_item,
  input  evf_pkg::evf_cfg_t                 cfg,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [evf_pkg::CH_W-1:0]          out_channel,
  output logic signed [evf_pkg::RAW_W-1:0]  out_raw_velocity,
  output logic signed [evf_pkg::FILT_W-1:0] out_filtered_velocity,
  output logic signed [evf_pkg::POS_W-1:0]  out_position,
  output logic                              out_last
);
  import evf_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int N_OUT = (NUM_CHANNELS < MAX_OUT) ? NUM_CHANNELS : MAX_OUT;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_LOAD = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_SAT  = 8'b0001_0000,
    S_FMUL = 8'b0010_0000,
    S_FADD = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          cnt_r, cnt_nxt;
  logic [DT_W-1:0]           dt_r;
  logic [POS_W-1:0]          pos_r   [NUM_CHANNELS];
  logic [POS_W-1:0]          last_r  [NUM_CHANNELS];
  logic signed [RAW_W-1:0]   vprev_r [NUM_CHANNELS];
  logic signed [FILT_W-1:0]  filt_r  [NUM_CHANNELS];
  logic signed [NUM_W-1:0]   num_r;
  logic [MAG_W-1:0]          dq_r;
  logic [DT_W-1:0]           rem_r;
  logic [DIVCNT_W-1:0]       bit_r;
  logic                      neg_r;
  logic signed [RAW_W-1:0]   raw_r;
  logic signed [PROD1_W-1:0] p1_r;
  logic signed [PROD2_W-1:0] p2_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic                      out_valid_r;
  logic [CH_W-1:0]           out_ch_r;
  logic signed [RAW_W-1:0]   out_raw_r;
  logic signed [FILT_W-1:0]  out_filt_r;
  logic signed [POS_W-1:0]   out_pos_r;
  logic                      out_last_r;

  logic [IDX_W-1:0]          idx;
  logic signed [POS_W-1:0]   diff_s;
  logic signed [NUM_W-1:0]   num_nxt;
  logic [NUM_W-1:0]          num_abs;
  logic [DT_W:0]             rem_sh;
  logic [DT_W+1:0]           rem_sub;
  logic                      q_bit;
  logic signed [RAW_W-1:0]   raw_nxt;
  logic signed [SUM_W-1:0]   sum_s;
  logic signed [PROD1_W-1:0] p1_nxt;
  logic signed [PROD2_W-1:0] p2_nxt;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [SH_W-1:0]    fshift;
  logic signed [FILT_W-1:0]  fnew;
  logic                      slot_free;
  logic                      is_last;

  assign idx       = (state_r == S_IDLE) ? IDX_W'(q_item.channel) : cnt_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign slot_free = !out_valid_r || out_ready;
  assign is_last   = (cnt_r == IDX_W'(N_OUT - 1));

  assign diff_s  = $signed(pos_r[idx] - last_r[idx]);
  assign num_nxt = diff_s * $signed({1'b0, MS_PER_S});
  assign num_abs = num_r[NUM_W-1] ? NUM_W'(-num_r) : num_r;

  // one quotient bit per cycle
  assign rem_sh  = {rem_r, dq_r[MAG_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, dt_r};
  assign q_bit   = !rem_sub[DT_W+1];

  always_comb begin
    if (!neg_r) begin
      if (dq_r[MAG_W-1:RAW_W-1] != '0) begin
        raw_nxt = {1'b0, {(RAW_W-1){1'b1}}};
      end else begin
        raw_nxt = $signed(dq_r[RAW_W-1:0]);
      end
    end else begin
      if ((dq_r[MAG_W-1:RAW_W] != '0) ||
          (dq_r[RAW_W-1] && (dq_r[RAW_W-2:0] != '0))) begin
        raw_nxt = {1'b1, {(RAW_W-1){1'b0}}};
      end else begin
        raw_nxt = $signed(RAW_W'(-dq_r[RAW_W-1:0]));
      end
    end
  end

  assign sum_s   = raw_r + vprev_r[idx];
  assign p1_nxt  = $signed({1'b0, cfg.pole}) * filt_r[idx];
  assign p2_nxt  = $signed({1'b0, cfg.in_coef}) * sum_s;
  assign acc_nxt = p1_r + (p2_r <<< 8) + ACC_ROUND;
  assign fshift  = $signed(acc_r[ACC_W-1:FRAC_W]);

  always_comb begin
    if ((&fshift[SH_W-1:FILT_W-1]) || !(|fshift[SH_W-1:FILT_W-1])) begin
      fnew = fshift[FILT_W-1:0];
    end else if (fshift[SH_W-1]) begin
      fnew = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      fnew = {1'b0, {(FILT_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && q_item.is_tick) begin
          state_nxt = S_MUL;
          cnt_nxt   = '0;
        end
      end
      S_MUL:  state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (bit_r == DIVCNT_W'(MAG_W - 1)) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT:  state_nxt = S_FMUL;
      S_FMUL: state_nxt = S_FADD;
      S_FADD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = is_last ? S_IDLE : S_MUL;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pos_r[c]   <= '0;
        last_r[c]  <= '0;
        vprev_r[c] <= '0;
        filt_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (q_pop && !q_item.is_tick) begin
        pos_r[idx] <= q_item.count_up ? pos_r[idx] + 1'b1 : pos_r[idx] - 1'b1;
      end
      if ((state_r == S_EMIT) && slot_free) begin
        last_r[idx]  <= pos_r[idx];
        vprev_r[idx] <= raw_r;
        filt_r[idx]  <= fnew;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_tick) begin
      dt_r <= q_item.elapsed;
    end
    if (state_r == S_MUL) begin
      num_r <= num_nxt;
    end
    if (state_r == S_LOAD) begin
      dq_r  <= num_abs[MAG_W-1:0];
      rem_r <= '0;
      bit_r <= '0;
      neg_r <= num_r[NUM_W-1];
    end
    if (state_r == S_DIV) begin
      rem_r <= q_bit ? rem_sub[DT_W-1:0] : rem_sh[DT_W-1:0];
      dq_r  <= {dq_r[MAG_W-2:0], q_bit};
      bit_r <= bit_r + 1'b1;
    end
    if (state_r == S_SAT) begin
      raw_r <= raw_nxt;
    end
    if (state_r == S_FMUL) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (state_r == S_FADD) begin
      acc_r <= acc_nxt;
    end
    if ((state_r == S_EMIT) && slot_free) begin
      out_ch_r   <= CH_W'(cnt_r);
      out_raw_r  <= raw_r;
      out_filt_r <= fnew;
      out_pos_r  <= $signed(pos_r[idx]);
      out_last_r <= is_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_channel           = out_ch_r;
  assign out_raw_velocity      = out_raw_r;
  assign out_filtered_velocity = out_filt_r;
  assign out_position          = out_pos_r;
  assign out_last              = out_last_r;

endmodule

FILE: dv/encoder_velocity_filter_top_tb.sv
// Self-checking testbench for encoder_velocity_filter_top: drives edge and tick items
// and APB register writes, predicts the per-channel velocity items and compares them.
// Depends on evf_pkg and the RTL under hdl/ only.
`timescale 1ns / 100ps

module encoder_velocity_filter_top_tb;
  import evf_pkg::*;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] REG_UNUSED_IDX = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_POLE   = {REG_POLE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_INPUT  = {REG_INPUT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_INVERT = {REG_INVERT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = {REG_UNUSED_IDX, 2'b00};

  localparam longint RAW_HI  = (longint'(1) <<< (RAW_W - 1)) - 1;
  localparam longint RAW_LO  = -(longint'(1) <<< (RAW_W - 1));
  localparam longint FILT_HI = (longint'(1) <<< (FILT_W - 1)) - 1;
  localparam longint FILT_LO = -(longint'(1) <<< (FILT_W - 1));

  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 200;
  localparam int HOLD_CYCLES     = 1500;
  localparam int FAST_EDGES      = 20;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int TIMEOUT_NS      = 4_000_000;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [RAW_W-1:0]  raw;
    logic [FILT_W-1:0] filt;
    logic [POS_W-1:0]  pos;
    logic              is_last;
  } velocity_t;

  class velocity_tracker;
    logic [COEF_W-1:0] pole_coef;
    logic [COEF_W-1:0] input_coef;
    logic [MASK_W-1:0] invert_mask;
    logic [POS_W-1:0]  position [MAX_OUT];
    logic [POS_W-1:0]  position_at_tick [MAX_OUT];
    longint            raw_prev [MAX_OUT];
    longint            filt_state [MAX_OUT];
    velocity_t         expected_velocities [$];
    int                errors;

    function new();
      pole_coef   = POLE_RESET;
      input_coef  = INPUT_RESET;
      invert_mask = MASK_RESET;
      for (int c = 0; c < MAX_OUT; c++) begin
        position[c]         = '0;
        position_at_tick[c] = '0;
        raw_prev[c]         = 0;
        filt_state[c]       = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      case (addr)
        ADDR_POLE:   pole_coef   = value[COEF_W-1:0];
        ADDR_INPUT:  input_coef  = value[COEF_W-1:0];
        ADDR_INVERT: invert_mask = value[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic cmd, logic [CH_W-1:0] ch, logic b_level,
                            logic [DT_W-1:0] elapsed);
      logic [POS_W-1:0] delta;
      longint span, diff, raw, acc, filt, a_w, b_w, ms;
      velocity_t v;
      if (cmd == CMD_EDGE) begin
        if (b_level ^ invert_mask[ch]) position[ch] = position[ch] + 1'b1;
        else position[ch] = position[ch] - 1'b1;
        return;
      end
      // zero elapsed counts as one millisecond
      span = (elapsed == '0) ? 1 : elapsed;
      a_w  = pole_coef;
      b_w  = input_coef;
      ms   = MS_PER_S;
      for (int c = 0; c < MAX_OUT; c++) begin
        delta = position[c] - position_at_tick[c];
        diff  = $signed(delta);
        raw   = diff * ms / span;
        if (raw > RAW_HI) raw = RAW_HI;
        if (raw < RAW_LO) raw = RAW_LO;
        acc  = a_w * filt_state[c] + b_w * ((raw + raw_prev[c]) * 256);
        filt = (acc + ACC_ROUND) >>> FRAC_W;
        if (filt > FILT_HI) filt = FILT_HI;
        if (filt < FILT_LO) filt = FILT_LO;
        filt_state[c]       = filt;
        raw_prev[c]         = raw;
        position_at_tick[c] = position[c];
        v.ch      = CH_W'(c);
        v.raw     = raw[RAW_W-1:0];
        v.filt    = filt[FILT_W-1:0];
        v.pos     = position[c];
        v.is_last = (c == MAX_OUT - 1);
        expected_velocities.push_back(v);
      end
    endfunction

    function void report(string field, longint exp_val, longint act_val);
      $display("%0t: ERROR %s expected %0d, got %0d", $time, field, exp_val, act_val);
      errors++;
    endfunction

    function void check_velocity(logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw,
                                 logic [FILT_W-1:0] filt, logic [POS_W-1:0] pos,
                                 logic is_last);
      velocity_t e;
      if (expected_velocities.size() == 0) begin
        $display("%0t: ERROR unexpected item on channel %0d", $time, ch);
        errors++;
        return;
      end
      e = expected_velocities.pop_front();
      if (ch !== e.ch) report("out_channel", e.ch, ch);
      if (raw !== e.raw) report("raw_velocity", $signed(e.raw), $signed(raw));
      if (filt !== e.filt) report("filtered_velocity", $signed(e.filt), $signed(filt));
      if (pos !== e.pos) report("position", $signed(e.pos), $signed(pos));
      if (is_last !== e.is_last) report("last", e.is_last, is_last);
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [IN_USER_W-1:0]  in_tuser    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [CH_W-1:0]       out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  velocity_tracker tracker = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int up_pct [MAX_OUT];
  bit hold_req   = 1'b0;
  bit hold_taken = 1'b0;

  always #2 clk = ~clk;

  encoder_velocity_filter_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_velocity(out_tuser, out_tdata[RAW_W-1:0],
                             out_tdata[RAW_W+FILT_W-1:RAW_W],
                             out_tdata[RAW_W+FILT_W+POS_W-1:RAW_W+FILT_W], out_tlast);
    end
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    tracker.write_reg(addr, value);
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] pole,
                           input logic [CFG_DATA_W-1:0] in_coef,
                           input logic [CFG_DATA_W-1:0] invert);
    cfg_write(ADDR_POLE, pole);
    cfg_write(ADDR_INPUT, in_coef);
    cfg_write(ADDR_INVERT, invert);
  endtask

  task automatic send_item(input logic cmd, input logic [CH_W-1:0] ch,
                           input logic b_level, input logic [DT_W-1:0] elapsed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({elapsed, b_level});
    in_tuser  <= {ch, cmd};
    do @(posedge clk); while (!in_tready);
    tracker.note_item(cmd, ch, b_level, elapsed);
  endtask

  task automatic send_random_item(input int tick_pct);
    logic [CH_W-1:0] ch;
    logic [DT_W-1:0] dt;
    int pick;
    ch = CH_W'($urandom_range(0, MAX_OUT - 1));
    dt = DT_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < tick_pct) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) dt = '0;
      else if (pick == 1) dt = '1;
      else if (pick > 3) dt = DT_W'($urandom_range(1, 20));
      send_item(CMD_TICK, ch, 1'($urandom_range(0, 1)), dt);
    end else begin
      send_item(CMD_EDGE, ch, ($urandom_range(0, 99) < up_pct[ch]), dt);
    end
  endtask

  task automatic send_edges(input logic [CH_W-1:0] ch, input logic b_level, input int n);
    repeat (n) send_item(CMD_EDGE, ch, b_level, DT_W'($urandom_range(0, 65535)));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.expected_velocities.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    #TIMEOUT_NS;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int m;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: channel 1 inverted
    send_item(CMD_TICK, 2'd0, 1'b0, 16'd0);
    send_edges(2'd0, 1'b1, 3);
    send_edges(2'd1, 1'b1, 2);
    send_edges(2'd2, 1'b0, 1);
    send_item(CMD_EDGE, 2'd3, 1'b1, 16'hFFFF);
    send_item(CMD_EDGE, 2'd1, 1'b0, 16'h0000);
    send_item(CMD_TICK, 2'd3, 1'b1, 16'd0);
    send_edges(2'd0, 1'b0, 2);
    send_item(CMD_EDGE, 2'd2, 1'b1, 16'h5555);
    send_item(CMD_TICK, 2'd1, 1'b0, 16'hFFFF);
    send_item(CMD_TICK, 2'd2, 1'b1, 16'd1);
    send_edges(2'd3, 1'b0, 2);
    send_item(CMD_TICK, 2'd0, 1'b0, 16'h8000);
    send_item(CMD_TICK, 2'd3, 1'b1, 16'd3);
    wait_idle();

    // largest coefficients, fast moves both ways; unused address is a no-op
    configure(32'hFFFF_FFFF, 32'h0000_7FFF, 32'h0);
    cfg_write(ADDR_UNUSED, $urandom());
    send_item(CMD_TICK, 2'd0, 1'b0, 16'd1);
    send_edges(2'd0, 1'b1, FAST_EDGES);
    send_item(CMD_TICK, 2'd0, 1'b0, 16'd1);
    send_edges(2'd0, 1'b0, FAST_EDGES);
    send_item(CMD_TICK, 2'd0, 1'b0, 16'd1);
    send_item(CMD_TICK, 2'd0, 1'b0, 16'd0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       configure(32'h0, 32'h0, 32'hF);
        1:       configure(32'h7FFF, 32'h7FFF, 32'h0);
        3:       configure(CFG_DATA_W'(POLE_RESET), CFG_DATA_W'(INPUT_RESET),
                           CFG_DATA_W'(MASK_RESET));
        default: configure($urandom(), $urandom(), $urandom());
      endcase
      m = p % 4;
      send_idle_pct  = (m == 1) ? 67 : (m == 3) ? 11 : 0;
      recv_stall_pct = (m == 2) ? 67 : (m == 3) ? 11 : 0;
      for (int c = 0; c < MAX_OUT; c++) up_pct[c] = $urandom_range(0, 100);
      if (p == 4) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_item((p == 4) ? 50 : 20);
      wait_idle();
    end

    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/evf_pkg.sv
hdl/evf_front.sv
hdl/evf_queue.sv
hdl/evf_back.sv
hdl/encoder_velocity_filter_top.sv
dv/encoder_velocity_filter_top_tb.sv
